>>> rtl/core/fbg_pkg.sv
package fbg_pkg;

  // Default sizes of the block
  localparam int FONT_BYTES_DEF      = 8192;
  localparam int MAX_FONT_WIDTH_DEF  = 16;
  localparam int MAX_FONT_HEIGHT_DEF = 32;
  localparam int COORD_BITS_DEF      = 12;

  // Fixed field widths
  localparam int FONT_WIDTH_W  = 5;
  localparam int FONT_HEIGHT_W = 6;
  localparam int PITCH_W       = 15;
  localparam int WORD_ADDR_W   = 30;
  localparam int COLOR_W       = 32;
  localparam int MASK_W        = 16;
  localparam int CFG_DATA_W    = 30;
  localparam int CFG_INDEX_W   = 2;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Input modes
  localparam logic [1:0] MODE_LOAD        = 2'd0;
  localparam logic [1:0] MODE_DRAW_XY     = 2'd1;
  localparam logic [1:0] MODE_DRAW_CURSOR = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE  = 2'd3;

  // Register reset values
  localparam logic [FONT_WIDTH_W-1:0]  FONT_WIDTH_RST  = 5'd8;
  localparam logic [FONT_HEIGHT_W-1:0] FONT_HEIGHT_RST = 6'd16;
  localparam logic [PITCH_W-1:0]       PITCH_RST       = 15'd4096;
  localparam logic [WORD_ADDR_W-1:0]   FRAME_BASE_RST  = '0;

  // Framebuffer geometry seen by the row sequencer
  typedef struct packed {
    logic [PITCH_W-1:0]     pitch;
    logic [WORD_ADDR_W-1:0] base;
  } fbg_geom_t;

  // One result beat
  typedef struct packed {
    logic [WORD_ADDR_W-1:0] word_address;
    logic [MASK_W-1:0]      pixel_mask;
    logic [COLOR_W-1:0]     row_color;
    logic                   last_row;
  } fbg_result_t;

  // Font bytes are MSB-first: bit 7 is the leftmost pixel
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fbg_ram.sv
module fbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/fbg_fifo.sv
module fbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  input  logic [WIDTH-1:0]           din,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/core/fbg_front.sv
module fbg_front #(
  parameter int FONT_BYTES      = fbg_pkg::FONT_BYTES_DEF,
  parameter int MAX_FONT_WIDTH  = fbg_pkg::MAX_FONT_WIDTH_DEF,
  parameter int MAX_FONT_HEIGHT = fbg_pkg::MAX_FONT_HEIGHT_DEF,
  parameter int COORD_BITS      = fbg_pkg::COORD_BITS_DEF,
  parameter int GLYPH_W         = 15,
  parameter int ACC_W           = 28,
  parameter int CMD_W           = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input beats
  input  logic                                 push,
  input  logic [1:0]                           mode,
  input  logic [11:0]                          x_pos,
  input  logic [11:0]                          y_pos,
  input  logic [7:0]                           character,
  input  logic [31:0]                          pixel_color,
  input  logic [12:0]                          load_index,
  input  logic [7:0]                           load_byte,
  input  logic                                 full,
  // configuration
  input  logic                                 cfg_write,
  input  logic [fbg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fbg_pkg::CFG_DATA_W-1:0]       cfg_data,
  // command queue
  output logic                                 cmd_push,
  output logic [CMD_W-1:0]                     cmd_data,
  output fbg_pkg::fbg_geom_t                   geom
);

  localparam logic [GLYPH_W:0] FONT_LIMIT = (GLYPH_W + 1)'(FONT_BYTES);

  logic [fbg_pkg::FONT_WIDTH_W-1:0]  font_width, w_eff;
  logic [fbg_pkg::FONT_HEIGHT_W-1:0] font_height, h_eff;
  logic [fbg_pkg::PITCH_W-1:0]       pitch_bytes;
  logic [fbg_pkg::WORD_ADDR_W-1:0]   frame_base_word;
  logic [COORD_BITS-1:0]             cursor_col, cursor_row;
  logic [COORD_BITS-1:0]             x_sel, y_sel, col_next;
  logic                              bpr2;
  logic [fbg_pkg::MASK_W-1:0]        wmask;
  logic [13:0]                       char_h;
  logic [GLYPH_W-1:0]                glyph, load_addr;
  logic [ACC_W-1:0]                  acc;
  logic                              accept, is_draw, load_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_width      <= fbg_pkg::FONT_WIDTH_RST;
      font_height     <= fbg_pkg::FONT_HEIGHT_RST;
      pitch_bytes     <= fbg_pkg::PITCH_RST;
      frame_base_word <= fbg_pkg::FRAME_BASE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        fbg_pkg::REG_FONT_WIDTH:  font_width      <= cfg_data[fbg_pkg::FONT_WIDTH_W-1:0];
        fbg_pkg::REG_FONT_HEIGHT: font_height     <= cfg_data[fbg_pkg::FONT_HEIGHT_W-1:0];
        fbg_pkg::REG_PITCH:       pitch_bytes     <= cfg_data[fbg_pkg::PITCH_W-1:0];
        fbg_pkg::REG_FRAME_BASE:  frame_base_word <= cfg_data;
        default: ;
      endcase
    end
  end

  assign geom.pitch = pitch_bytes;
  assign geom.base  = frame_base_word;

  // clamp glyph size
  always_comb begin
    if (font_width == '0) begin
      w_eff = 5'd1;
    end else if (font_width > 5'(MAX_FONT_WIDTH)) begin
      w_eff = 5'(MAX_FONT_WIDTH);
    end else begin
      w_eff = font_width;
    end
    if (font_height == '0) begin
      h_eff = 6'd1;
    end else if (font_height > 6'(MAX_FONT_HEIGHT)) begin
      h_eff = 6'(MAX_FONT_HEIGHT);
    end else begin
      h_eff = font_height;
    end
  end

  // one or two font bytes per glyph row
  assign bpr2   = (w_eff > 5'd8);
  assign wmask  = fbg_pkg::MASK_W'((17'd1 << w_eff) - 17'd1);
  assign char_h = {6'd0, character} * {8'd0, h_eff};
  assign glyph  = bpr2 ? (GLYPH_W'(char_h) << 1) : GLYPH_W'(char_h);

  // origin: explicit or cursor
  assign x_sel    = (mode == fbg_pkg::MODE_DRAW_XY) ? COORD_BITS'(x_pos) : cursor_col;
  assign y_sel    = (mode == fbg_pkg::MODE_DRAW_XY) ? COORD_BITS'(y_pos) : cursor_row;
  assign col_next = x_sel + COORD_BITS'(w_eff);
  assign acc      = ACC_W'(y_sel) * ACC_W'(pitch_bytes);

  // classify
  assign accept    = push && !full;
  assign is_draw   = (mode == fbg_pkg::MODE_DRAW_XY) || (mode == fbg_pkg::MODE_DRAW_CURSOR);
  assign load_addr = GLYPH_W'(load_index);
  assign load_ok   = (mode == fbg_pkg::MODE_LOAD) && ({1'b0, load_addr} < FONT_LIMIT);
  assign cmd_push  = accept && (is_draw || load_ok);

  // command word: load, color, x, y*pitch, glyph start, height, two bytes, width mask
  always_comb begin
    if (is_draw) begin
      cmd_data = {1'b0, pixel_color, x_sel, acc, glyph, h_eff, bpr2, wmask};
    end else begin
      cmd_data = {1'b1, 32'd0, COORD_BITS'(0), ACC_W'(0), load_addr,
                  fbg_pkg::FONT_HEIGHT_W'(0), 1'b0, 8'd0, load_byte};
    end
  end

  // text cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept && is_draw) begin
      cursor_col <= col_next;
      cursor_row <= y_sel;
    end
  end

  a_cursor_advance: assert property (@(posedge clk) disable iff (rst)
    (push && !full && mode == fbg_pkg::MODE_DRAW_CURSOR) |=>
      (cursor_col == $past(col_next) && $stable(cursor_row)))
    else $error("cursor did not advance by the glyph width");

endmodule

>>> rtl/core/fbg_back.sv
module fbg_back #(
  parameter int FONT_BYTES = fbg_pkg::FONT_BYTES_DEF,
  parameter int COORD_BITS = fbg_pkg::COORD_BITS_DEF,
  parameter int GLYPH_W    = 15,
  parameter int ACC_W      = 28,
  parameter int CMD_W      = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  // command queue
  input  logic                               cmd_empty,
  input  logic [CMD_W-1:0]                   cmd_data,
  output logic                               cmd_pop,
  input  fbg_pkg::fbg_geom_t                 geom,
  // font store
  output logic                               ram_we,
  output logic [$clog2(FONT_BYTES)-1:0]      ram_waddr,
  output logic [7:0]                         ram_wdata,
  output logic [$clog2(FONT_BYTES)-1:0]      ram_raddr,
  input  logic [7:0]                         ram_rdata,
  // result queue
  input  logic [fbg_pkg::OUT_CNT_W-1:0]      out_count,
  output logic                               res_push,
  output fbg_pkg::fbg_result_t               res
);

  localparam int RAM_AW = $clog2(FONT_BYTES);
  localparam int HW     = fbg_pkg::FONT_HEIGHT_W;
  localparam int O_B2   = fbg_pkg::MASK_W;
  localparam int O_H    = O_B2 + 1;
  localparam int O_G    = O_H + HW;
  localparam int O_A    = O_G + GLYPH_W;
  localparam int O_X    = O_A + ACC_W;
  localparam int O_C    = O_X + COORD_BITS;
  localparam int O_L    = O_C + fbg_pkg::COLOR_W;
  localparam logic [GLYPH_W:0] FONT_LIMIT = (GLYPH_W + 1)'(FONT_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ROWS = 2'b10
  } fbg_state_t;

  fbg_state_t                        state;
  logic [fbg_pkg::COLOR_W-1:0]       color_r;
  logic [COORD_BITS-1:0]             x_r;
  logic [ACC_W-1:0]                  acc_r;
  logic [GLYPH_W-1:0]                idx_r;
  logic [HW-1:0]                     h_r, row_cnt;
  logic                              bpr2_r, phase;
  logic [fbg_pkg::MASK_W-1:0]        wmask_r;

  logic                              cmd_is_load, issue, final_byte, row_last;
  logic [fbg_pkg::WORD_ADDR_W-1:0]   row_addr;

  // read tag, registered so that it lines up with the RAM read data
  logic                              t_valid, t_final, t_zero, t_two, t_last;
  logic [fbg_pkg::WORD_ADDR_W-1:0]   t_addr;
  logic [fbg_pkg::COLOR_W-1:0]       t_color;
  logic [fbg_pkg::MASK_W-1:0]        t_wmask;
  logic [7:0]                        byte0_r, rd_byte, lo_byte, hi_byte;

  // command intake; loads go straight to the font store
  assign cmd_is_load = cmd_data[O_L];
  assign cmd_pop     = (state == ST_IDLE) && !cmd_empty;
  assign ram_we      = cmd_pop && cmd_is_load;
  assign ram_waddr   = cmd_data[O_G +: RAM_AW];
  assign ram_wdata   = cmd_data[7:0];

  // row issue: keep room for the beat already in flight
  assign issue      = (state == ST_ROWS) &&
                      (out_count <= fbg_pkg::OUT_CNT_W'(fbg_pkg::OUT_DEPTH - 2));
  assign final_byte = !bpr2_r || phase;
  assign row_last   = (row_cnt == h_r - 1'b1);
  assign ram_raddr  = idx_r[RAM_AW-1:0];
  assign row_addr   = geom.base + fbg_pkg::WORD_ADDR_W'(x_r)
                    + fbg_pkg::WORD_ADDR_W'(acc_r >> 2);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      t_valid <= 1'b0;
    end else begin
      t_valid <= issue;
      case (state)
        ST_IDLE: begin
          if (cmd_pop && !cmd_is_load) begin
            color_r <= cmd_data[O_C +: fbg_pkg::COLOR_W];
            x_r     <= cmd_data[O_X +: COORD_BITS];
            acc_r   <= cmd_data[O_A +: ACC_W];
            idx_r   <= cmd_data[O_G +: GLYPH_W];
            h_r     <= cmd_data[O_H +: HW];
            bpr2_r  <= cmd_data[O_B2];
            wmask_r <= cmd_data[fbg_pkg::MASK_W-1:0];
            row_cnt <= '0;
            phase   <= 1'b0;
            state   <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
            if (final_byte) begin
              phase   <= 1'b0;
              row_cnt <= row_cnt + 1'b1;
              acc_r   <= acc_r + ACC_W'(geom.pitch);
              if (row_last) begin
                state <= ST_IDLE;
              end
            end else begin
              phase <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tag payload
  always_ff @(posedge clk) begin
    if (issue) begin
      t_final <= final_byte;
      t_zero  <= ({1'b0, idx_r} >= FONT_LIMIT);
      t_two   <= bpr2_r;
      t_last  <= row_last;
      t_addr  <= row_addr;
      t_color <= color_r;
      t_wmask <= wmask_r;
    end
    if (t_valid && !t_final) begin
      byte0_r <= rd_byte;
    end
  end

  // mask assembly; bytes past the store read as zero
  assign rd_byte = t_zero ? 8'd0 : ram_rdata;
  assign lo_byte = t_two ? byte0_r : rd_byte;
  assign hi_byte = t_two ? rd_byte : 8'd0;

  assign res_push         = t_valid && t_final;
  assign res.word_address = t_addr;
  assign res.pixel_mask   = {fbg_pkg::rev8(hi_byte), fbg_pkg::rev8(lo_byte)} & t_wmask;
  assign res.row_color    = t_color;
  assign res.last_row     = t_last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < fbg_pkg::OUT_CNT_W'(fbg_pkg::OUT_DEPTH)))
    else $error("result beat pushed into a full queue");

  a_tag_from_rows: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> $past(state == ST_ROWS))
    else $error("font read issued outside a glyph");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWS) |-> (row_cnt < h_r))
    else $error("row counter ran past glyph height");

endmodule

>>> rtl/core/bitmap_font_glyph_blitter_unit.sv
// Bitmap font glyph blitter.
// Input channel (push/full): one beat per command. Mode 0 stores a font byte,
// mode 1 draws a glyph at x_pos/y_pos, mode 2 draws at the text cursor; mode 3
// is dropped. Output channel (empty/pop): one beat per glyph row with the word
// address of the row start, a pixel mask, the color and a last-row flag.
// Configuration: cfg_write/cfg_index/cfg_data, to be written only while idle;
// the block itself does not enforce this. The first row of a glyph passes
// the command queue, the row sequencer, the font RAM read and the result queue;
// a row spanning two font bytes waits for its second byte. A draw holds the
// row sequencer until every font byte of every glyph row has been read through
// the single read port of the font RAM; a load just writes its byte.
// A four-entry command queue sits between the classifier and the row
// sequencer, so commands keep flowing in while rows are being drawn.
// Reset clears both queues, the cursor and the registers (width 8, height 16,
// pitch 4096, base 0); font store contents are unknown until loaded.
// When the receiver stalls, up to four rows wait in the result queue, the
// sequencer pauses, and full rises once four commands are queued.
module bitmap_font_glyph_blitter_unit #(
  parameter int FONT_BYTES      = fbg_pkg::FONT_BYTES_DEF,
  parameter int MAX_FONT_WIDTH  = fbg_pkg::MAX_FONT_WIDTH_DEF,
  parameter int MAX_FONT_HEIGHT = fbg_pkg::MAX_FONT_HEIGHT_DEF,
  parameter int COORD_BITS      = fbg_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // commands
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       mode,
  input  logic [11:0]                      x_pos,
  input  logic [11:0]                      y_pos,
  input  logic [7:0]                       character,
  input  logic [31:0]                      pixel_color,
  input  logic [12:0]                      load_index,
  input  logic [7:0]                       load_byte,
  // row writes
  output logic                             empty,
  input  logic                             pop,
  output logic [29:0]                      word_address,
  output logic [15:0]                      pixel_mask,
  output logic [31:0]                      row_color,
  output logic                             last_row,
  // configuration
  input  logic                             cfg_write,
  input  logic [fbg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fbg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RAM_AW  = $clog2(FONT_BYTES);
  localparam int GW_A    = 9 + $clog2(MAX_FONT_HEIGHT + 1);
  localparam int GLYPH_W = (GW_A > RAM_AW + 1) ? GW_A : RAM_AW + 1;
  localparam int ACC_W   = COORD_BITS + 1 + fbg_pkg::PITCH_W;
  localparam int CMD_W   = 1 + fbg_pkg::COLOR_W + COORD_BITS + ACC_W + GLYPH_W
                         + fbg_pkg::FONT_HEIGHT_W + 1 + fbg_pkg::MASK_W;
  localparam int RES_W   = $bits(fbg_pkg::fbg_result_t);

  logic                             cmd_push, cmd_pop, cmd_empty;
  logic [CMD_W-1:0]                 cmd_in, cmd_out;
  fbg_pkg::fbg_geom_t               geom;
  logic                             ram_we;
  logic [RAM_AW-1:0]                ram_waddr, ram_raddr;
  logic [7:0]                       ram_wdata, ram_rdata;
  logic [fbg_pkg::OUT_CNT_W-1:0]    out_count;
  logic                             res_push;
  fbg_pkg::fbg_result_t             res_in, res_out;

  fbg_front #(
    .FONT_BYTES      (FONT_BYTES),
    .MAX_FONT_WIDTH  (MAX_FONT_WIDTH),
    .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT),
    .COORD_BITS      (COORD_BITS),
    .GLYPH_W         (GLYPH_W),
    .ACC_W           (ACC_W),
    .CMD_W           (CMD_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .mode        (mode),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .character   (character),
    .pixel_color (pixel_color),
    .load_index  (load_index),
    .load_byte   (load_byte),
    .full        (full),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_in),
    .geom        (geom)
  );

  fbg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (fbg_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .pop   (cmd_pop),
    .din   (cmd_in),
    .dout  (cmd_out),
    .full  (full),
    .empty (cmd_empty),
    .count ()
  );

  fbg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbg_back #(
    .FONT_BYTES (FONT_BYTES),
    .COORD_BITS (COORD_BITS),
    .GLYPH_W    (GLYPH_W),
    .ACC_W      (ACC_W),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .geom      (geom),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  fbg_fifo #(
    .WIDTH (RES_W),
    .DEPTH (fbg_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .pop   (pop),
    .din   (res_in),
    .dout  (res_out),
    .full  (),
    .empty (empty),
    .count (out_count)
  );

  assign word_address = res_out.word_address;
  assign pixel_mask   = res_out.pixel_mask;
  assign row_color    = res_out.row_color;
  assign last_row     = res_out.last_row;

endmodule

>>> tb/tb_bitmap_font_glyph_blitter_unit.sv
`timescale 1ns / 100ps

module tb_bitmap_font_glyph_blitter_unit;

  localparam int FONT_BYTES = fbg_pkg::FONT_BYTES_DEF;
  localparam int MAX_W = fbg_pkg::MAX_FONT_WIDTH_DEF;
  localparam int MAX_H = fbg_pkg::MAX_FONT_HEIGHT_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 70;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 800000;
  localparam int MAX_REPORTS = 30;
  // hand-drawn glyph rows for the directed font load, first row in the top byte
  localparam logic [127:0] ARROW_GLYPH = 128'h8001FF00AA55183C7EC3F00F814224E7;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [1:0] mode;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic [7:0] character;
  logic [31:0] pixel_color;
  logic [12:0] load_index;
  logic [7:0] load_byte;
  logic empty;
  logic pop;
  logic [29:0] word_address;
  logic [15:0] pixel_mask;
  logic [31:0] row_color;
  logic last_row;
  logic cfg_write;
  logic [fbg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [fbg_pkg::CFG_DATA_W-1:0] cfg_data;

  bitmap_font_glyph_blitter_unit uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .character(character),
    .pixel_color(pixel_color),
    .load_index(load_index),
    .load_byte(load_byte),
    .empty(empty),
    .pop(pop),
    .word_address(word_address),
    .pixel_mask(pixel_mask),
    .row_color(row_color),
    .last_row(last_row),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the font store, cursor and registers
  logic [7:0] font_copy [FONT_BYTES];
  bit font_known [FONT_BYTES];
  logic [11:0] cur_col;
  logic [11:0] cur_row;
  logic [fbg_pkg::FONT_WIDTH_W-1:0] reg_width;
  logic [fbg_pkg::FONT_HEIGHT_W-1:0] reg_height;
  logic [fbg_pkg::PITCH_W-1:0] reg_pitch;
  logic [fbg_pkg::WORD_ADDR_W-1:0] reg_base;

  fbg_pkg::fbg_result_t row_writes_due [$];
  int mismatches = 0;
  int rows_checked = 0;
  int glyphs_drawn = 0;
  int bytes_loaded = 0;
  int items_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit bursty = 1'b1;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int glyph_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return int'(reg_width);
  endfunction

  function automatic int glyph_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_H) return MAX_H;
    return int'(reg_height);
  endfunction

  // Row writes of one glyph draw, then the cursor step
  function automatic void blit_glyph(input logic [1:0] md, input logic [11:0] xp,
                                     input logic [11:0] yp, input logic [7:0] ch,
                                     input logic [31:0] color);
    int w, h, bpr, start, idx;
    logic [11:0] gx, gy;
    logic [63:0] line, addr;
    fbg_pkg::fbg_result_t r;
    w = glyph_width();
    h = glyph_height();
    bpr = (w + 7) / 8;
    start = int'(ch) * bpr * h;
    gx = (md == fbg_pkg::MODE_DRAW_XY) ? xp : cur_col;
    gy = (md == fbg_pkg::MODE_DRAW_XY) ? yp : cur_row;
    for (int row = 0; row < h; row++) begin
      line = ((64'(gy) + 64'(row)) * 64'(reg_pitch)) >> 2;
      addr = 64'(reg_base) + 64'(gx) + line;
      r.word_address = addr[fbg_pkg::WORD_ADDR_W-1:0];
      r.pixel_mask = '0;
      for (int col = 0; col < w; col++) begin
        idx = start + row * bpr + col / 8;
        // bytes past the store read as zero
        if (idx < FONT_BYTES && font_copy[idx][7 - col % 8]) r.pixel_mask[col] = 1'b1;
      end
      r.row_color = color;
      r.last_row = (row == h - 1);
      row_writes_due.push_back(r);
    end
    cur_col = gx + 12'(w);
    cur_row = gy;
    glyphs_drawn++;
  endfunction

  function automatic logic [7:0] font_pattern();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] coord();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] color();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Send one command beat; while bursty is set, sender pacing comes in bursts with gaps
  task automatic issue_command(input logic [1:0] md, input logic [11:0] xp,
                               input logic [11:0] yp, input logic [7:0] ch,
                               input logic [31:0] clr, input logic [12:0] idx,
                               input logic [7:0] data);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    @(negedge clk);
    push <= 1'b1;
    mode <= md;
    x_pos <= xp;
    y_pos <= yp;
    character <= ch;
    pixel_color <= clr;
    load_index <= idx;
    load_byte <= data;
    do @(posedge clk); while (full);
    // beat accepted: update the shadow model
    if (md == fbg_pkg::MODE_LOAD) begin
      font_copy[idx] = data;
      font_known[idx] = 1'b1;
      bytes_loaded++;
    end else if (md == fbg_pkg::MODE_DRAW_XY || md == fbg_pkg::MODE_DRAW_CURSOR) begin
      blit_glyph(md, xp, yp, ch, clr);
    end
    if (md != MODE_SPARE) items_sent++;
  endtask

  // Load every store byte of a glyph that has not been written yet
  task automatic ensure_glyph(input logic [7:0] ch);
    int span, start;
    span = ((glyph_width() + 7) / 8) * glyph_height();
    start = int'(ch) * span;
    for (int i = start; i < start + span && i < FONT_BYTES; i++) begin
      if (!font_known[i])
        issue_command(fbg_pkg::MODE_LOAD, 12'($urandom), 12'($urandom), 8'($urandom),
                      $urandom, 13'(i), font_pattern());
    end
  endtask

  task automatic draw_glyph(input logic [1:0] md, input logic [11:0] xp,
                            input logic [11:0] yp, input logic [7:0] ch,
                            input logic [31:0] clr);
    ensure_glyph(ch);
    issue_command(md, xp, yp, ch, clr, 13'($urandom), 8'($urandom));
  endtask

  // Stop sending and let every expected row and queued load drain
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (row_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbg_pkg::CFG_INDEX_W-1:0] index,
                           input logic [fbg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      fbg_pkg::REG_FONT_WIDTH: reg_width = value[fbg_pkg::FONT_WIDTH_W-1:0];
      fbg_pkg::REG_FONT_HEIGHT: reg_height = value[fbg_pkg::FONT_HEIGHT_W-1:0];
      fbg_pkg::REG_PITCH: reg_pitch = value[fbg_pkg::PITCH_W-1:0];
      fbg_pkg::REG_FRAME_BASE: reg_base = value[fbg_pkg::WORD_ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // Program all registers while idle; unused upper data bits carry junk
  task automatic set_geometry(input int w, input int h, input int pitch,
                              input logic [29:0] base);
    logic [fbg_pkg::CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = fbg_pkg::CFG_DATA_W'($urandom);
    write_reg(fbg_pkg::REG_FONT_WIDTH, {junk[29:5], 5'(w)});
    write_reg(fbg_pkg::REG_FONT_HEIGHT, {junk[29:6], 6'(h)});
    write_reg(fbg_pkg::REG_PITCH, {junk[29:15], 15'(pitch)});
    write_reg(fbg_pkg::REG_FRAME_BASE, base);
    settings_used++;
  endtask

  // Reset geometry: hand-made glyph, corner positions, cursor wrap, spare mode
  task automatic test_default_font();
    for (int i = 0; i < 16; i++)
      issue_command(fbg_pkg::MODE_LOAD, 12'($urandom), 12'($urandom), 8'($urandom),
                    $urandom, 13'(16 + i), ARROW_GLYPH[127 - 8 * i -: 8]);
    issue_command(fbg_pkg::MODE_LOAD, 12'($urandom), 12'($urandom), 8'($urandom),
                  $urandom, 13'h1FFF, 8'hFF);
    draw_glyph(fbg_pkg::MODE_DRAW_XY, 12'd0, 12'd0, 8'd1, 32'h0);
    draw_glyph(fbg_pkg::MODE_DRAW_XY, 12'hFFF, 12'hFFF, 8'd1, 32'hFFFF_FFFF);
    // column wraps past 4095
    draw_glyph(fbg_pkg::MODE_DRAW_CURSOR, 12'($urandom), 12'($urandom), 8'd1,
               32'hA5A5_5A5A);
    issue_command(MODE_SPARE, 12'($urandom), 12'($urandom), 8'd1, $urandom,
                  13'd16, 8'h00);
    draw_glyph(fbg_pkg::MODE_DRAW_CURSOR, 12'($urandom), 12'($urandom), 8'd1,
               32'h5A5A_A5A5);
    issue_command(fbg_pkg::MODE_LOAD, 12'($urandom), 12'($urandom), 8'($urandom),
                  $urandom, 13'd0, 8'h81);
    draw_glyph(fbg_pkg::MODE_DRAW_XY, 12'd7, 12'd300, 8'd0, $urandom);
    draw_glyph(fbg_pkg::MODE_DRAW_XY, 12'd100, 12'd0, 8'd255, $urandom);
  endtask

  task automatic try_geometry(input int w, input int h, input int pitch,
                              input logic [29:0] base);
    int span;
    set_geometry(w, h, pitch, base);
    span = ((glyph_width() + 7) / 8) * glyph_height();
    draw_glyph(fbg_pkg::MODE_DRAW_XY, 12'hFFF, 12'hFFF, 8'd255, color());
    draw_glyph(fbg_pkg::MODE_DRAW_CURSOR, coord(), coord(), 8'd0, color());
    if (span <= 16)
      draw_glyph(fbg_pkg::MODE_DRAW_XY, coord(), coord(), 8'($urandom), color());
  endtask

  // Clamped sizes, odd and tiny pitches, address wrap, glyphs past the store
  task automatic test_geometry_extremes();
    try_geometry(0, 0, 0, 30'd0);
    try_geometry(31, 63, 32767, 30'h3FFF_FFFF);
    // glyph 127 ends on the last store byte, glyph 128 starts just past it
    draw_glyph(fbg_pkg::MODE_DRAW_XY, coord(), coord(), 8'd127, color());
    draw_glyph(fbg_pkg::MODE_DRAW_XY, coord(), coord(), 8'd128, color());
    try_geometry(16, 32, 4, 30'h3FFF_FF00);
    try_geometry(9, 5, 1, 30'($urandom));
    try_geometry(1, 1, 3, 30'($urandom));
    try_geometry(17, 33, 16384, 30'($urandom));
  endtask

  // Random phases: random geometry, mostly load-then-draw on a small glyph set
  task automatic test_random_traffic();
    int counted, phase, start_items, pick, w, h, pitch;
    logic [7:0] pool [5];
    logic [7:0] ch;
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(17, 31);
        2, 3, 4: w = $urandom_range(9, 16);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = $urandom_range(33, 63);
        2: h = $urandom_range(13, 32);
        default: h = $urandom_range(1, 12);
      endcase
      pitch = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32767)
                                          : 4 * $urandom_range(1, 4096);
      set_geometry(w, h, pitch, 30'($urandom));
      bursty = (phase % 3 != 1);
      foreach (pool[i]) pool[i] = 8'($urandom);
      start_items = items_sent;
      while (items_sent - start_items < 40 &&
             counted + items_sent - start_items < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          issue_command(MODE_SPARE, coord(), coord(), 8'($urandom), color(),
                        13'($urandom), 8'($urandom));
        end else if (pick < 18) begin
          issue_command(fbg_pkg::MODE_LOAD, coord(), coord(), 8'($urandom), color(),
                        13'($urandom), font_pattern());
        end else begin
          ch = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 4)] : 8'($urandom);
          draw_glyph((pick < 58) ? fbg_pkg::MODE_DRAW_XY : fbg_pkg::MODE_DRAW_CURSOR,
                     coord(), coord(), ch, color());
        end
      end
      counted += items_sent - start_items;
      phase++;
    end
    bursty = 1'b1;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Row write checker: every popped beat against the oldest expectation
  always @(posedge clk) begin : row_check
    fbg_pkg::fbg_result_t want;
    if (!rst && pop && !empty) begin
      if (row_writes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected row write, expected none, actual address 0x%0h mask 0x%0h",
                   $time, word_address, pixel_mask);
      end else begin
        want = row_writes_due.pop_front();
        check_field("word_address", 32'(want.word_address), 32'(word_address));
        check_field("pixel_mask", 32'(want.pixel_mask), 32'(pixel_mask));
        check_field("row_color", want.row_color, row_color);
        check_field("last_row", 32'(want.last_row), 32'(last_row));
        rows_checked++;
      end
    end
  end

  // Receiver: changes stall style at random intervals
  initial begin : receiver
    int style, span;
    logic [7:0] pat;
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      pat = 8'($urandom) | 8'h01;
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (style)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom);
          2: pop <= pat[k % 8];
          default: pop <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    mode = fbg_pkg::MODE_LOAD;
    x_pos = '0;
    y_pos = '0;
    character = '0;
    pixel_color = '0;
    load_index = '0;
    load_byte = '0;
    cfg_write = 1'b0;
    cfg_index = fbg_pkg::REG_FONT_WIDTH;
    cfg_data = '0;
    cur_col = '0;
    cur_row = '0;
    reg_width = fbg_pkg::FONT_WIDTH_RST;
    reg_height = fbg_pkg::FONT_HEIGHT_RST;
    reg_pitch = fbg_pkg::PITCH_RST;
    reg_base = fbg_pkg::FRAME_BASE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_font();
    test_geometry_extremes();
    test_random_traffic();
    wait_idle();

    $display("Drew %0d glyphs and loaded %0d font bytes over %0d register settings;",
             glyphs_drawn, bytes_loaded, settings_used);
    $display("checked %0d row writes in %0d cycles, %0d mismatches.",
             rows_checked, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fbg_pkg.sv
rtl/core/fbg_ram.sv
rtl/core/fbg_fifo.sv
rtl/core/fbg_front.sv
rtl/core/fbg_back.sv
rtl/core/bitmap_font_glyph_blitter_unit.sv
tb/tb_bitmap_font_glyph_blitter_unit.sv
